// File: design/gqbp_pkg.sv
// Shared constants and types for the gray quantizer and bit packer.
package gqbp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned FillW  = 3;   // filled bits of the pending byte, 0 to 7
  localparam int unsigned WidthW = 4;   // code width, 1 to 8
  localparam int unsigned CntW   = 2;   // results per pixel, 0 to 2

  localparam logic [ByteW-1:0]  LevelReset = 8'd255;
  localparam logic [CntW-1:0]   CntNone    = 2'd0;
  localparam logic [CntW-1:0]   CntOne     = 2'd1;
  localparam logic [CntW-1:0]   CntTwo     = 2'd2;

  // Bytes produced by one pixel, in delivery order.
  typedef struct packed {
    logic [CntW-1:0]  cnt;
    logic [ByteW-1:0] byte0;
    logic             last0;
    logic [ByteW-1:0] byte1;
    logic             last1;
  } pack_res_t;

endpackage

// File: design/gray_quantize_bit_packer_core.sv
// Gray pixel quantizer with MSB-first bit packing: top level.
// Each accepted 8-bit pixel is quantized to floor(pixel * max_level / 255) and written as a
// code just wide enough for max_level (a level of 0 acts as 1); codes are packed MSB-first
// and every completed byte goes out as one beat. On a pixel with last_pixel_i set, any
// partial byte is sent zero-padded and the final beat carries last_byte_o. A pixel is taken
// every cycle while the result register can take the held pixel's bytes; its bytes pass
// through the input register, then the result register. A last pixel that yields two bytes
// holds the result register for two output beats, and the next pixel waits until the last of
// them leaves. Write max_level only while the block is idle; the new level applies from the next pixel on.
module gray_quantize_bit_packer_core import gqbp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] pixel_value_i,
  input  logic             last_pixel_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] packed_byte_o,
  output logic             last_byte_o
);

  logic [ByteW-1:0]  max_level_q;
  logic              s1_valid_q, s1_valid_d;
  logic [ByteW-1:0]  pixel_q;
  logic              last_q;
  logic [ByteW-1:0]  code;
  logic [WidthW-1:0] width;
  pack_res_t         pack_res;
  logic              load_ok, advance, in_fire, out_fire;
  logic [CntW-1:0]   res_cnt_q, res_cnt_d;
  logic [ByteW-1:0]  res_byte0_q, res_byte1_q;
  logic              res_last0_q, res_last1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= LevelReset;
    end else if (cfg_we_i) begin
      max_level_q <= cfg_wdata_i;
    end
  end

  // The result register takes a new pixel's bytes when it is empty or its last byte drains this cycle.
  assign load_ok    = (res_cnt_q == CntNone) || ((res_cnt_q == CntOne) && out_ready_i);
  assign advance    = s1_valid_q && load_ok;
  assign in_ready_o = !s1_valid_q || load_ok;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_o && out_ready_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pixel_q <= pixel_value_i;
      last_q  <= last_pixel_i;
    end
  end

  gqbp_quant u_quant (
    .max_level_i (max_level_q),
    .pixel_i     (pixel_q),
    .code_o      (code),
    .width_o     (width)
  );

  gqbp_pack u_pack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .code_i    (code),
    .width_i   (width),
    .last_i    (last_q),
    .res_o     (pack_res)
  );

  always_comb begin
    res_cnt_d = res_cnt_q;
    if (advance) begin
      res_cnt_d = pack_res.cnt;
    end else if (out_fire) begin
      res_cnt_d = res_cnt_q - CntOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= CntNone;
    end else begin
      res_cnt_q <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_byte0_q <= pack_res.byte0;
      res_last0_q <= pack_res.last0;
      res_byte1_q <= pack_res.byte1;
      res_last1_q <= pack_res.last1;
    end else if (out_fire) begin
      res_byte0_q <= res_byte1_q;
      res_last0_q <= res_last1_q;
    end
  end

  assign out_valid_o   = (res_cnt_q != CntNone);
  assign packed_byte_o = res_byte0_q;
  assign last_byte_o   = res_last0_q;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q != 2'd3)
    else $error("result count out of range");

  a_two_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_cnt_q == CntTwo) |-> !res_last0_q)
    else $error("first of two held bytes flagged last");

  a_two_only_on_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && pack_res.cnt == CntTwo) |-> (last_q && pack_res.last1))
    else $error("two bytes from a pixel that is not a flush");
`endif

endmodule

// File: design/gqbp_quant.sv
// Quantizer: scales a pixel to floor(pixel * level / 255) and gives the code width.
module gqbp_quant import gqbp_pkg::*; (
  input  logic [ByteW-1:0]  max_level_i,
  input  logic [ByteW-1:0]  pixel_i,
  output logic [ByteW-1:0]  code_o,
  output logic [WidthW-1:0] width_o
);

  logic [ByteW-1:0]   level;
  logic [2*ByteW-1:0] prod;
  logic [2*ByteW:0]   sum;

  assign level = (max_level_i == '0) ? ByteW'(1) : max_level_i;
  assign prod  = {{ByteW{1'b0}}, pixel_i} * {{ByteW{1'b0}}, level};

  // Exact x / 255 for any x up to 255 * 255, i.e. every product of two 8-bit values: (x + (x >> 8) + 1) >> 8.
  assign sum    = {1'b0, prod} + {{(ByteW+1){1'b0}}, prod[2*ByteW-1:ByteW]}
                + (2*ByteW+1)'(1);
  assign code_o = sum[2*ByteW-1:ByteW];

  always_comb begin
    width_o = '0;
    for (int i = 0; i < ByteW; i++) begin
      if (level[i]) begin
        width_o = WidthW'(i + 1);
      end
    end
  end

endmodule

// File: design/gqbp_pack.sv
// Packer: merges codes MSB-first, emits full bytes, flushes the rest on last.
module gqbp_pack import gqbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [ByteW-1:0]  code_i,
  input  logic [WidthW-1:0] width_i,
  input  logic              last_i,
  output pack_res_t         res_o
);

  logic [ByteW-1:0]   partial_q, partial_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [4:0]         total;
  logic [4:0]         shamt;
  logic [2*ByteW-1:0] win;
  logic [ByteW-1:0]   part_nxt;
  logic [FillW-1:0]   fill_nxt;

  assign total = {2'b00, fill_q} + {1'b0, width_i};
  assign shamt = 5'd16 - total;
  // Pending bits on top, the new code directly below them.
  assign win   = {partial_q, {ByteW{1'b0}}} | ((2*ByteW)'(code_i) << shamt);

  always_comb begin
    res_o = '0;
    if (total >= 5'd8) begin
      res_o.cnt   = CntOne;
      res_o.byte0 = win[2*ByteW-1:ByteW];
      part_nxt    = win[ByteW-1:0];
      fill_nxt    = FillW'(total - 5'd8);
    end else begin
      part_nxt    = win[2*ByteW-1:ByteW];
      fill_nxt    = total[FillW-1:0];
    end

    partial_d = part_nxt;
    fill_d    = fill_nxt;
    if (last_i) begin
      // Flush even an all-zero partial byte; the final beat carries the flag.
      if (fill_nxt != '0) begin
        if (res_o.cnt == CntOne) begin
          res_o.cnt   = CntTwo;
          res_o.byte1 = part_nxt;
          res_o.last1 = 1'b1;
        end else begin
          res_o.cnt   = CntOne;
          res_o.byte0 = part_nxt;
          res_o.last0 = 1'b1;
        end
      end else if (res_o.cnt == CntOne) begin
        res_o.last0 = 1'b1;
      end
      partial_d = '0;
      fill_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      fill_q    <= '0;
    end else if (advance_i) begin
      partial_q <= partial_d;
      fill_q    <= fill_d;
    end
  end

endmodule
